@@ hdl/assert_macros.svh @@
// Assertion macros shared by the dimmer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  `ASSERT_HOLDS(lbl, clk, rst, !(expr), msg)
`else
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

@@ hdl/mpd_pkg.sv @@
// Types, codes and mode rules of the phase dimmer.
`default_nettype none
package mpd_pkg;

  localparam int CHANNELS = 12;
  localparam int CH_IW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int KEY_W    = 4;

  typedef enum logic [1:0] {
    OP_BUS  = 2'd0,
    OP_ZERO = 2'd1,
    OP_TICK = 2'd2,
    OP_KEY  = 2'd3
  } op_t;

  localparam logic REG_BASE     = 1'b0;
  localparam logic REG_DEBOUNCE = 1'b1;

  localparam logic [7:0] FRAME_START     = 8'd250;
  localparam logic [7:0] BROADCAST_ADDR  = 8'd100;
  localparam logic [7:0] INTENSITY_LIMIT = 8'd40;
  localparam logic [7:0] PHASE_SPAN      = 8'd39;
  localparam logic [7:0] RELEASE_EARLY   = 8'd35;
  localparam logic [7:0] RELEASE_LATE    = 8'd74;
  localparam logic [7:0] GATED_LIMIT     = 8'd99;

  localparam logic [7:0] MODE_OFF       = 8'd80;
  localparam logic [7:0] MODE_ON        = 8'd90;
  localparam logic [7:0] MODE_MAX       = 8'd102;
  localparam logic [7:0] MODE_MEDIUM    = 8'd95;
  localparam logic [7:0] MODE_MINIMUM   = 8'd96;
  localparam logic [7:0] MODE_ALARM_ON  = 8'd140;
  localparam logic [7:0] MODE_ALARM_OFF = 8'd141;
  localparam logic [7:0] MODE_BLINK_HI0 = 8'd120;
  localparam logic [7:0] MODE_BLINK_LO0 = 8'd70;

  localparam logic [6:0] LEVEL_DARK   = 7'd95;
  localparam logic [6:0] LEVEL_FULL   = 7'd0;
  localparam logic [6:0] LEVEL_MEDIUM = 7'd17;
  localparam logic [6:0] LEVEL_MIN    = 7'd23;

  localparam logic [15:0] DEBOUNCE_RESET = 16'd755;
  localparam logic [7:0]  BASE_RESET     = 8'd81;

  typedef struct packed {
    op_t             op;
    logic [7:0]      rx_byte;
    logic [7:0]      phase;
    logic [KEY_W-1:0] key_index;
    logic            key_level;
  } item_t;

  typedef struct packed {
    logic                has_gate;
    logic                has_report;
    logic [CHANNELS-1:0] gates;
    logic [7:0]          addr;
    logic [7:0]          val;
  } result_t;

  typedef struct packed {
    logic [7:0] mode;
    logic [6:0] level;
    logic       lock;
    logic       unlock;
  } rule_t;

  function automatic rule_t apply_rules(logic [7:0] mode, logic [5:0] inten,
                                        logic [6:0] level, logic [7:0] cc);
    rule_t r;
    r.mode   = mode;
    r.level  = level;
    r.lock   = 1'b0;
    r.unlock = 1'b0;
    if (r.mode == MODE_OFF) r.level = LEVEL_DARK;
    if (r.mode == MODE_ON) begin
      if (inten == 6'd0) r.mode = MODE_MAX;
      else r.level = {1'b0, inten};
    end
    if (r.mode == MODE_MAX) r.level = LEVEL_FULL;
    if (r.mode == MODE_MEDIUM) r.level = LEVEL_MEDIUM;
    if (r.mode == MODE_MINIMUM) r.level = LEVEL_MIN;
    for (int k = 0; k < 4; k++) begin
      if (r.mode == MODE_BLINK_HI0 + 8'(k) || r.mode == MODE_BLINK_LO0 + 8'(k)) begin
        if (cc[7-k]) begin
          r.mode  = MODE_BLINK_HI0 + 8'(k);
          r.level = LEVEL_FULL;
        end else begin
          r.mode  = MODE_BLINK_LO0 + 8'(k);
          r.level = LEVEL_DARK;
        end
      end
    end
    if (r.mode == MODE_ALARM_ON) begin
      r.lock = 1'b1;
      r.mode = MODE_BLINK_HI0 + 8'd2;
    end
    if (r.mode == MODE_ALARM_OFF) begin
      r.unlock = 1'b1;
      r.mode   = MODE_ON;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mpd_engine.sv @@
// Channel state, deframer, debounce and gate logic of the dimmer.
`default_nettype none
`include "assert_macros.svh"
module mpd_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire mpd_pkg::item_t   item,
  input  wire logic [7:0]       module_base,
  input  wire logic [15:0]      debounce_count,
  output mpd_pkg::result_t      res
);

  localparam int CH = mpd_pkg::CHANNELS;
  localparam int IW = mpd_pkg::CH_IW;

  logic [5:0]  intensity [CH];
  logic [7:0]  mode [CH];
  logic [6:0]  fire_level [CH];
  logic [CH-1:0] gate_bits;
  logic [CH-1:0] key_stable;
  logic [15:0] debounce_counter [CH];
  logic        keys_enabled;
  logic [7:0]  crossing_count;
  logic [1:0]  frame_index;
  logic [7:0]  frame_bytes [2];

  logic [5:0]  intensity_next [CH];
  logic [7:0]  mode_next [CH];
  logic [6:0]  fire_level_next [CH];
  logic [CH-1:0] gate_bits_next;
  logic [CH-1:0] key_stable_next;
  logic [15:0] debounce_counter_next [CH];
  logic        keys_enabled_next;
  logic [7:0]  crossing_count_next;
  logic [1:0]  frame_index_next;
  logic [7:0]  frame_bytes_next [2];

  logic [7:0]  off;
  logic        off_ok;
  logic        bcast;
  logic        sum_ok;
  logic [IW-1:0] kidx;
  logic        key_ok;
  logic [15:0] dc_inc;
  logic        toggle;
  logic [7:0]  toggle_val;
  logic        release_tick;

  assign off    = frame_bytes[0] - module_base;
  assign off_ok = off < 8'(CH);
  assign bcast  = frame_bytes[0] == mpd_pkg::BROADCAST_ADDR;
  assign sum_ok = (frame_bytes[0] + frame_bytes[1]) == item.rx_byte;
  assign kidx   = item.key_index[IW-1:0];
  assign key_ok = keys_enabled &&
                  ({1'b0, item.key_index} < (mpd_pkg::KEY_W + 1)'(CH));
  assign dc_inc = debounce_counter[kidx] + 16'd1;
  assign toggle = key_ok && (item.key_level != key_stable[kidx]) &&
                  (dc_inc == debounce_count);
  assign toggle_val = (mode[kidx] == mpd_pkg::MODE_ON || mode[kidx] == mpd_pkg::MODE_MAX)
                      ? mpd_pkg::MODE_OFF : mpd_pkg::MODE_ON;
  assign release_tick = item.phase == mpd_pkg::RELEASE_EARLY ||
                        item.phase == mpd_pkg::RELEASE_LATE;

  always_comb begin
    mpd_pkg::rule_t r;
    logic [CH-1:0] g;
    g                   = gate_bits;
    intensity_next      = intensity;
    mode_next           = mode;
    fire_level_next     = fire_level;
    gate_bits_next      = gate_bits;
    key_stable_next     = key_stable;
    debounce_counter_next = debounce_counter;
    keys_enabled_next   = keys_enabled;
    crossing_count_next = crossing_count;
    frame_index_next    = frame_index;
    frame_bytes_next    = frame_bytes;
    unique case (item.op)
      mpd_pkg::OP_BUS: begin
        if (item.rx_byte == mpd_pkg::FRAME_START) begin
          frame_index_next = 2'd0;
        end else if (frame_index < 2'd2) begin
          frame_bytes_next[frame_index[0]] = item.rx_byte;
          frame_index_next = frame_index + 2'd1;
        end else begin
          frame_index_next = 2'd0;
          if (sum_ok) begin
            for (int c = 0; c < CH; c++) begin
              if ((off_ok && off[IW-1:0] == IW'(c)) || bcast) begin
                if (frame_bytes[1] < mpd_pkg::INTENSITY_LIMIT) begin
                  intensity_next[c] = frame_bytes[1][5:0];
                end else begin
                  mode_next[c] = frame_bytes[1];
                end
              end
            end
          end
        end
      end
      mpd_pkg::OP_ZERO: begin
        crossing_count_next = crossing_count + 8'd1;
      end
      mpd_pkg::OP_TICK: begin
        for (int c = 0; c < CH; c++) begin
          if (item.phase == {1'b0, fire_level[c]} ||
              item.phase == {1'b0, fire_level[c]} + mpd_pkg::PHASE_SPAN) begin
            g[c] = 1'b1;
          end
          if (release_tick && mode[c] < mpd_pkg::GATED_LIMIT) g[c] = 1'b0;
        end
        gate_bits_next = g;
      end
      mpd_pkg::OP_KEY: begin
        if (key_ok) begin
          if (item.key_level == key_stable[kidx]) begin
            debounce_counter_next[kidx] = 16'd0;
          end else if (toggle) begin
            debounce_counter_next[kidx] = 16'd0;
            key_stable_next[kidx]       = item.key_level;
            mode_next[kidx]             = toggle_val;
          end else begin
            debounce_counter_next[kidx] = dc_inc;
          end
        end
      end
      default: begin
      end
    endcase
    for (int c = 0; c < CH; c++) begin
      r = mpd_pkg::apply_rules(mode_next[c], intensity_next[c], fire_level_next[c],
                               crossing_count_next);
      mode_next[c]       = r.mode;
      fire_level_next[c] = r.level;
      if (r.lock) keys_enabled_next = 1'b0;
      if (r.unlock) keys_enabled_next = 1'b1;
    end
  end

  always_comb begin
    res.has_gate   = item.op == mpd_pkg::OP_TICK;
    res.has_report = (item.op == mpd_pkg::OP_KEY) && toggle;
    res.gates      = gate_bits_next;
    res.addr       = module_base + 8'(kidx);
    res.val        = toggle_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CH; c++) begin
        intensity[c]        <= 6'd0;
        mode[c]             <= mpd_pkg::MODE_OFF;
        fire_level[c]       <= mpd_pkg::LEVEL_DARK;
        debounce_counter[c] <= 16'd0;
      end
      gate_bits      <= '0;
      key_stable     <= '0;
      keys_enabled   <= 1'b1;
      crossing_count <= 8'd0;
      frame_index    <= 2'd0;
    end else if (fire) begin
      intensity        <= intensity_next;
      mode             <= mode_next;
      fire_level       <= fire_level_next;
      debounce_counter <= debounce_counter_next;
      gate_bits        <= gate_bits_next;
      key_stable       <= key_stable_next;
      keys_enabled     <= keys_enabled_next;
      crossing_count   <= crossing_count_next;
      frame_index      <= frame_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) frame_bytes <= frame_bytes_next;
  end

  `ASSERT_NEVER(a_frame_index_range, clk, rst, frame_index == 2'd3, "frame index out of range")
  `ASSERT_HOLDS(a_zero_keeps_gates, clk, rst, fire && item.op == mpd_pkg::OP_ZERO |=> $stable(gate_bits), "gates moved on a crossing")

endmodule
`default_nettype wire

@@ hdl/multichannel_phase_dimmer.sv @@
// Top level of the multichannel phase dimmer: config port, item and result buffers.
// The block takes one item per clock. An item passes an input register and is
// applied to the channel state when the engine fires it; a phase tick yields one gate beat
// and an accepted key change yields a four-beat report frame, drained one beat per
// cycle from the result buffer while the receiver is ready, so input stalls only while an earlier beat is still
// waiting (a gate beat held by the receiver or the rest of a report) and the next
// item has results of its own. Bytes other than frame starts fill
// a two-byte address/value store before the checksum byte completes a frame.
`default_nettype none
`include "assert_macros.svh"
module multichannel_phase_dimmer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   operation,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [7:0]                   phase,
  input  wire logic [mpd_pkg::KEY_W-1:0]    key_index,
  input  wire logic                         key_level,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              kind,
  output logic [7:0]                        tx_byte,
  output logic                              last,
  output logic [mpd_pkg::CHANNELS-1:0]      gates
);

  logic [7:0]  module_base;
  logic [15:0] debounce_count;
  mpd_pkg::item_t   item;
  logic             item_valid;
  mpd_pkg::result_t res;
  logic             fire;
  logic             produces;
  logic             out_free;
  logic [2:0]       cnt;
  logic             rep_kind;
  logic [mpd_pkg::CHANNELS-1:0] rep_gates;
  logic [7:0]       rep_addr;
  logic [7:0]       rep_val;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_base    <= mpd_pkg::BASE_RESET;
      debounce_count <= mpd_pkg::DEBOUNCE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        mpd_pkg::REG_BASE:     module_base    <= pwdata[7:0];
        mpd_pkg::REG_DEBOUNCE: debounce_count <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mpd_pkg::REG_BASE:     prdata = {24'd0, module_base};
      mpd_pkg::REG_DEBOUNCE: prdata = {16'd0, debounce_count};
      default:               prdata = 32'd0;
    endcase
  end

  assign produces = res.has_gate || res.has_report;
  assign out_free = (cnt == 3'd0) || (cnt == 3'd1 && out_ready);
  assign fire     = item_valid && (out_free || !produces);
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.op        <= mpd_pkg::op_t'(operation);
      item.rx_byte   <= rx_byte;
      item.phase     <= phase;
      item.key_index <= key_index;
      item.key_level <= key_level;
    end
  end

  mpd_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (item),
    .module_base    (module_base),
    .debounce_count (debounce_count),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (fire && produces) begin
      cnt <= res.has_gate ? 3'd1 : 3'd4;
    end else if (out_valid && out_ready) begin
      cnt <= cnt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produces) begin
      rep_kind  <= res.has_report;
      rep_gates <= res.gates;
      rep_addr  <= res.addr;
      rep_val   <= res.val;
    end
  end

  assign out_valid = cnt != 3'd0;
  assign kind      = rep_kind;
  assign gates     = rep_kind ? '0 : rep_gates;
  assign last      = rep_kind && (cnt == 3'd1);

  always_comb begin
    tx_byte = 8'd0;
    if (rep_kind) begin
      case (cnt)
        3'd4:    tx_byte = mpd_pkg::FRAME_START;
        3'd3:    tx_byte = rep_addr;
        3'd2:    tx_byte = rep_val;
        3'd1:    tx_byte = rep_addr + rep_val;
        default: tx_byte = 8'd0;
      endcase
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst, cnt > 3'd4, "result count out of range")
  `ASSERT_HOLDS(a_gate_single, clk, rst, out_valid && !kind |-> cnt == 3'd1, "gate beat not single")
  `ASSERT_HOLDS(a_room, clk, rst, fire && produces |-> out_free, "results overwrite pending beats")
  `ASSERT_HOLDS(a_report_holds, clk, rst, out_valid && out_ready && cnt > 3'd1 |=> out_valid, "report frame cut short")

endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the multichannel phase dimmer, with a built-in behavioral predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_BASE     = {mpd_pkg::REG_BASE, 2'b00};
  localparam logic [2:0] ADDR_DEBOUNCE = {mpd_pkg::REG_DEBOUNCE, 2'b00};
  localparam int         DIRECTED_ROWS = 25;
  localparam int         STALL_CYCLES  = 300;
  localparam int         CHN           = mpd_pkg::CHANNELS;
  localparam int         KW            = mpd_pkg::KEY_W;

  typedef struct packed {
    logic           kind;
    logic [7:0]     tx;
    logic           last;
    logic [CHN-1:0] gates;
  } beat_t;

  typedef struct packed {
    mpd_pkg::op_t   op;
    logic [7:0]     rx;
    logic [7:0]     ph;
    logic [KW-1:0]  ki;
    logic           kl;
    logic           typed;
    logic [CHN-1:0] tg;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic [7:0] rx_byte = '0;
  logic [7:0] phase = '0;
  logic [KW-1:0] key_index = '0;
  logic key_level = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [7:0] tx_byte;
  logic last;
  logic [CHN-1:0] gates;

  multichannel_phase_dimmer dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .operation, .rx_byte, .phase, .key_index, .key_level,
    .out_valid, .out_ready, .kind, .tx_byte, .last, .gates
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // dimmer state as the predictor sees it
  logic [7:0]     cfg_base;
  logic [15:0]    cfg_deb;
  logic [5:0]     lum [CHN];
  logic [7:0]     md [CHN];
  logic [6:0]     lvl [CHN];
  logic [CHN-1:0] gate_q;
  logic           stable [CHN];
  logic [15:0]    cnt [CHN];
  logic           keys_on;
  logic [7:0]     zc;
  int             fidx;
  logic [7:0]     fbuf [2];

  beat_t pending_beats[$];
  int    bad_beats = 0;
  int    used_items;
  bit    tx_steady = 1'b0;
  bit    rx_steady = 1'b0;
  bit    stall_req = 1'b0;
  int    stall_cycles = 0;
  int    rx_hold = 0;
  row_t  plan [DIRECTED_ROWS];

  function automatic beat_t mk_beat(logic k, logic [7:0] t, logic l, logic [CHN-1:0] g);
    beat_t b;
    b.kind  = k;
    b.tx    = t;
    b.last  = l;
    b.gates = g;
    return b;
  endfunction

  function automatic void run_mode_rules();
    logic [7:0] hi, lo;
    for (int c = 0; c < CHN; c++) begin
      if (md[c] == mpd_pkg::MODE_OFF) lvl[c] = mpd_pkg::LEVEL_DARK;
      if (md[c] == mpd_pkg::MODE_ON) begin
        if (lum[c] == 6'd0) md[c] = mpd_pkg::MODE_MAX;
        else lvl[c] = {1'b0, lum[c]};
      end
      if (md[c] == mpd_pkg::MODE_MAX) lvl[c] = mpd_pkg::LEVEL_FULL;
      if (md[c] == mpd_pkg::MODE_MEDIUM) lvl[c] = mpd_pkg::LEVEL_MEDIUM;
      if (md[c] == mpd_pkg::MODE_MINIMUM) lvl[c] = mpd_pkg::LEVEL_MIN;
      for (int k = 0; k < 4; k++) begin
        hi = mpd_pkg::MODE_BLINK_HI0 + 8'(k);
        lo = mpd_pkg::MODE_BLINK_LO0 + 8'(k);
        if (md[c] == hi || md[c] == lo) begin
          if (zc[7-k]) begin
            md[c]  = hi;
            lvl[c] = mpd_pkg::LEVEL_FULL;
          end else begin
            md[c]  = lo;
            lvl[c] = mpd_pkg::LEVEL_DARK;
          end
        end
      end
      if (md[c] == mpd_pkg::MODE_ALARM_ON) begin
        keys_on = 1'b0;
        md[c]   = mpd_pkg::MODE_BLINK_HI0 + 8'd2;
      end
      if (md[c] == mpd_pkg::MODE_ALARM_OFF) begin
        keys_on = 1'b1;
        md[c]   = mpd_pkg::MODE_ON;
      end
    end
  endfunction

  function automatic void set_channel(int c, logic [7:0] v);
    if (v < mpd_pkg::INTENSITY_LIMIT) lum[c] = v[5:0];
    else md[c] = v;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    logic [7:0] a, v, off, sum;
    if (b == mpd_pkg::FRAME_START) begin
      fidx = 0;
      return;
    end
    if (fidx < 2) begin
      fbuf[fidx] = b;
      fidx++;
      return;
    end
    fidx = 0;
    a    = fbuf[0];
    v    = fbuf[1];
    off  = a - cfg_base;
    sum  = a + v;
    if (sum != b) return;
    if (off < CHN) set_channel(int'(off), v);
    if (a == mpd_pkg::BROADCAST_ADDR)
      for (int c = 0; c < CHN; c++) set_channel(c, v);
  endfunction

  function automatic void fire_tick(logic [7:0] ph);
    int lv;
    for (int c = 0; c < CHN; c++) begin
      lv = int'(lvl[c]);
      if (int'(ph) == lv || int'(ph) == lv + int'(mpd_pkg::PHASE_SPAN)) gate_q[c] = 1'b1;
    end
    if (ph == mpd_pkg::RELEASE_EARLY || ph == mpd_pkg::RELEASE_LATE)
      for (int c = 0; c < CHN; c++)
        if (md[c] < mpd_pkg::GATED_LIMIT) gate_q[c] = 1'b0;
    pending_beats.push_back(mk_beat(1'b0, 8'd0, 1'b0, gate_q));
  endfunction

  function automatic void key_change(logic [KW-1:0] idx, logic lv);
    logic [7:0] addr, val;
    if (!keys_on || idx >= CHN) return;
    if (lv == stable[idx]) begin
      cnt[idx] = '0;
      return;
    end
    cnt[idx] = cnt[idx] + 16'd1;
    if (cnt[idx] != cfg_deb) return;
    cnt[idx]    = '0;
    stable[idx] = lv;
    val     = (md[idx] == mpd_pkg::MODE_ON || md[idx] == mpd_pkg::MODE_MAX)
              ? mpd_pkg::MODE_OFF : mpd_pkg::MODE_ON;
    md[idx] = val;
    addr    = cfg_base + 8'(idx);
    pending_beats.push_back(mk_beat(1'b1, mpd_pkg::FRAME_START, 1'b0, '0));
    pending_beats.push_back(mk_beat(1'b1, addr, 1'b0, '0));
    pending_beats.push_back(mk_beat(1'b1, val, 1'b0, '0));
    pending_beats.push_back(mk_beat(1'b1, 8'(addr + val), 1'b1, '0));
  endfunction

  function automatic void dimmer_step(mpd_pkg::item_t it);
    case (it.op)
      mpd_pkg::OP_BUS:  take_byte(it.rx_byte);
      mpd_pkg::OP_ZERO: zc = zc + 8'd1;
      mpd_pkg::OP_TICK: fire_tick(it.phase);
      default:          key_change(it.key_index, it.key_level);
    endcase
    run_mode_rules();
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic mpd_pkg::item_t noisy_item(mpd_pkg::op_t op);
    mpd_pkg::item_t it;
    it.op        = op;
    it.rx_byte   = 8'($urandom_range(0, 255));
    it.phase     = 8'($urandom_range(0, 255));
    it.key_index = KW'($urandom_range(0, 15));
    it.key_level = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic logic [7:0] pick_mode();
    int k;
    k = $urandom_range(0, 14);
    case (k)
      0: return mpd_pkg::MODE_OFF;
      1: return mpd_pkg::MODE_ON;
      2: return mpd_pkg::MODE_MAX;
      3: return mpd_pkg::MODE_MEDIUM;
      4: return mpd_pkg::MODE_MINIMUM;
      5: return mpd_pkg::MODE_ALARM_ON;
      6: return mpd_pkg::MODE_ALARM_OFF;
      7, 8, 9, 10: return mpd_pkg::MODE_BLINK_HI0 + 8'(k - 7);
      default: return mpd_pkg::MODE_BLINK_LO0 + 8'(k - 11);
    endcase
  endfunction

  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 2))
      0: return 8'($urandom_range(0, 39));
      1: return pick_mode();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_item(mpd_pkg::item_t it, int gap, logic typed, logic [CHN-1:0] tg);
    int depth;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation = it.op;
    rx_byte   = it.rx_byte;
    phase     = it.phase;
    key_index = it.key_index;
    key_level = it.key_level;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    depth = pending_beats.size();
    dimmer_step(it);
    if (typed) begin
      while (pending_beats.size() > depth) void'(pending_beats.pop_back());
      pending_beats.push_back(mk_beat(1'b0, 8'd0, 1'b0, tg));
    end
  endtask

  task automatic offer(mpd_pkg::item_t it);
    logic skipped;
    skipped = (it.op == mpd_pkg::OP_KEY) && (!keys_on || it.key_index >= CHN);
    send_item(it, pick_gap(), 1'b0, '0);
    if (!skipped) used_items++;
  endtask

  task automatic offer_byte(logic [7:0] b);
    mpd_pkg::item_t it;
    it         = noisy_item(mpd_pkg::OP_BUS);
    it.rx_byte = b;
    offer(it);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] a, logic [31:0] d);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = a;
    pwdata  = d;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (a == ADDR_BASE) cfg_base = d[7:0];
    else cfg_deb = d[15:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic random_traffic(int budget);
    int r, n, idx, reps;
    logic [7:0] a, v, chk;
    logic want;
    mpd_pkg::item_t it;
    used_items = 0;
    while (used_items < budget) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if ($urandom_range(0, 9) == 0) offer_byte(8'($urandom_range(0, 255)));
        offer_byte(mpd_pkg::FRAME_START);
        r = $urandom_range(0, 99);
        if (r < 40) a = 8'(cfg_base + $urandom_range(0, CHN - 1));
        else if (r < 55) a = 8'(cfg_base + $urandom_range(CHN, 20));
        else if (r < 80) a = mpd_pkg::BROADCAST_ADDR;
        else a = 8'($urandom_range(0, 255));
        v = pick_value();
        offer_byte(a);
        offer_byte(v);
        r = $urandom_range(0, 99);
        if (r < 80) chk = a + v;
        else if (r < 88) chk = 8'($urandom_range(0, 255));
        else chk = mpd_pkg::FRAME_START;
        if (r < 94) offer_byte(chk);
      end else if (r < 65) begin
        it = noisy_item(mpd_pkg::OP_TICK);
        r  = $urandom_range(0, 99);
        if (r < 20) begin
          it.phase = $urandom_range(0, 1) ? mpd_pkg::RELEASE_EARLY : mpd_pkg::RELEASE_LATE;
        end else if (r < 65) begin
          idx      = $urandom_range(0, CHN - 1);
          it.phase = 8'(lvl[idx]) + ($urandom_range(0, 1) ? mpd_pkg::PHASE_SPAN : 8'd0);
        end
        offer(it);
      end else if (r < 75) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 64) : 1;
        repeat (n) offer(noisy_item(mpd_pkg::OP_ZERO));
      end else if (r < 93) begin
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(CHN, 15)
                                          : $urandom_range(0, CHN - 1);
        if (idx < CHN) begin
          want = ~stable[idx];
          if (cnt[idx] >= cfg_deb) begin
            it           = noisy_item(mpd_pkg::OP_KEY);
            it.key_index = KW'(idx);
            it.key_level = stable[idx];
            offer(it);
          end
        end else begin
          want = 1'($urandom_range(0, 1));
        end
        reps = (cfg_deb <= 16'd4) ? $urandom_range(1, int'(cfg_deb) + 1) : $urandom_range(1, 6);
        repeat (reps) begin
          it           = noisy_item(mpd_pkg::OP_KEY);
          it.key_index = KW'(idx);
          it.key_level = ($urandom_range(0, 4) == 0) ? ~want : want;
          offer(it);
        end
      end else begin
        offer(noisy_item(mpd_pkg::op_t'($urandom_range(0, 3))));
      end
    end
  endtask

  always @(negedge clk) begin
    int r;
    if (rst) begin
      out_ready = 1'b0;
    end else if (stall_req) begin
      out_ready = 1'b0;
      stall_cycles++;
      if (stall_cycles >= STALL_CYCLES) begin
        stall_cycles = 0;
        stall_req    = 1'b0;
      end
    end else if (rx_hold > 0) begin
      out_ready = 1'b0;
      rx_hold--;
    end else if (rx_steady) begin
      out_ready = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b0;
        rx_hold   = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = mk_beat(kind, tx_byte, last, gates);
      if (pending_beats.size() == 0) begin
        if (bad_beats < 10)
          $display("unexpected beat: kind %0d tx %0d last %0d gates %03h",
                   got.kind, got.tx, got.last, got.gates);
        bad_beats++;
      end else begin
        want = pending_beats.pop_front();
        if (got.kind !== want.kind || got.tx !== want.tx || got.last !== want.last ||
            got.gates !== want.gates) begin
          if (bad_beats < 10)
            $display({"mismatch: expected kind %0d tx %0d last %0d gates %03h, ",
                      "got kind %0d tx %0d last %0d gates %03h"},
                     want.kind, want.tx, want.last, want.gates,
                     got.kind, got.tx, got.last, got.gates);
          bad_beats++;
        end
      end
    end
  end

  initial begin
    mpd_pkg::item_t it;
    cfg_base = mpd_pkg::BASE_RESET;
    cfg_deb  = mpd_pkg::DEBOUNCE_RESET;
    for (int c = 0; c < CHN; c++) begin
      lum[c]    = '0;
      md[c]     = mpd_pkg::MODE_OFF;
      lvl[c]    = mpd_pkg::LEVEL_DARK;
      stable[c] = 1'b0;
      cnt[c]    = '0;
    end
    gate_q  = '0;
    keys_on = 1'b1;
    zc      = '0;
    fidx    = 0;
    fbuf[0] = '0;
    fbuf[1] = '0;

    plan[0]  = '{mpd_pkg::OP_TICK, 8'd0, 8'd95, 4'd0, 1'b0, 1'b1, 12'hFFF};
    plan[1]  = '{mpd_pkg::OP_TICK, 8'd0, mpd_pkg::RELEASE_EARLY, 4'd0, 1'b0, 1'b1, 12'h000};
    plan[2]  = '{mpd_pkg::OP_TICK, 8'd0, 8'd255, 4'd0, 1'b0, 1'b1, 12'h000};
    plan[3]  = '{mpd_pkg::OP_BUS, 8'd81, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[4]  = '{mpd_pkg::OP_BUS, 8'd10, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[5]  = '{mpd_pkg::OP_BUS, 8'd91, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[6]  = '{mpd_pkg::OP_BUS, mpd_pkg::FRAME_START, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[7]  = '{mpd_pkg::OP_BUS, mpd_pkg::BROADCAST_ADDR, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[8]  = '{mpd_pkg::OP_BUS, mpd_pkg::MODE_ON, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[9]  = '{mpd_pkg::OP_BUS, mpd_pkg::FRAME_START, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[10] = '{mpd_pkg::OP_BUS, mpd_pkg::BROADCAST_ADDR, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[11] = '{mpd_pkg::OP_BUS, mpd_pkg::MODE_ON, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[12] = '{mpd_pkg::OP_BUS, 8'd190, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[13] = '{mpd_pkg::OP_TICK, 8'd0, 8'd10, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[14] = '{mpd_pkg::OP_BUS, mpd_pkg::FRAME_START, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[15] = '{mpd_pkg::OP_BUS, 8'd92, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[16] = '{mpd_pkg::OP_BUS, mpd_pkg::MODE_MINIMUM, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[17] = '{mpd_pkg::OP_BUS, 8'd0, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[18] = '{mpd_pkg::OP_KEY, 8'd0, 8'd0, 4'd12, 1'b1, 1'b0, 12'h000};
    plan[19] = '{mpd_pkg::OP_KEY, 8'd0, 8'd0, 4'd15, 1'b1, 1'b0, 12'h000};
    plan[20] = '{mpd_pkg::OP_KEY, 8'd0, 8'd0, 4'd0, 1'b1, 1'b0, 12'h000};
    plan[21] = '{mpd_pkg::OP_KEY, 8'd0, 8'd0, 4'd0, 1'b1, 1'b0, 12'h000};
    plan[22] = '{mpd_pkg::OP_ZERO, 8'd0, 8'd0, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[23] = '{mpd_pkg::OP_TICK, 8'd0, mpd_pkg::RELEASE_LATE, 4'd0, 1'b0, 1'b0, 12'h000};
    plan[24] = '{mpd_pkg::OP_KEY, 8'd0, 8'd0, 4'd11, 1'b0, 1'b0, 12'h000};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(ADDR_BASE, 32'd81);
    write_reg(ADDR_DEBOUNCE, 32'd2);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      it.op        = plan[i].op;
      it.rx_byte   = plan[i].rx;
      it.phase     = plan[i].ph;
      it.key_index = plan[i].ki;
      it.key_level = plan[i].kl;
      send_item(it, pick_gap(), plan[i].typed, plan[i].tg);
    end
    settle();
    random_traffic(25);

    settle();
    write_reg(ADDR_BASE, 32'd255);
    write_reg(ADDR_DEBOUNCE, 32'd1);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    random_traffic(8);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    random_traffic(12);

    settle();
    write_reg(ADDR_BASE, 32'd0);
    write_reg(ADDR_DEBOUNCE, 32'd65535);
    repeat (40) send_item(noisy_item(mpd_pkg::OP_ZERO), pick_gap(), 1'b0, '0);
    random_traffic(12);

    settle();
    write_reg(ADDR_BASE, 32'd137);
    write_reg(ADDR_DEBOUNCE, 32'd3);
    stall_req = 1'b1;
    tx_steady = 1'b1;
    repeat (16) send_item(noisy_item(mpd_pkg::OP_TICK), 0, 1'b0, '0);
    tx_steady = 1'b0;
    while (stall_req) @(posedge clk);
    random_traffic(15);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_beats == 0 && pending_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
